### sv/jst_pkg.sv
// Shared types, constants and lookup functions for the JSON syntax tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package jst_pkg;

   localparam int STACK_ENTRIES = 64;
   localparam int STACK_AW      = $clog2(STACK_ENTRIES);
   localparam int LIMIT_W       = (STACK_AW + 1 > 7) ? STACK_AW + 1 : 7;
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_AW        = $clog2(RSP_DEPTH);
   localparam int RSP_CW        = $clog2(RSP_DEPTH + 1);

   localparam logic [6:0] MAX_DEPTH_RESET = 7'd20;

   localparam logic [3:0] EV_NONE      = 4'd0;
   localparam logic [3:0] EV_OPEN_OBJ  = 4'd1;
   localparam logic [3:0] EV_OPEN_ARR  = 4'd2;
   localparam logic [3:0] EV_CLOSE_OBJ = 4'd3;
   localparam logic [3:0] EV_CLOSE_ARR = 4'd4;
   localparam logic [3:0] EV_STR_CHAR  = 4'd5;
   localparam logic [3:0] EV_STR_END   = 4'd6;
   localparam logic [3:0] EV_NUM_CHAR  = 4'd7;
   localparam logic [3:0] EV_NUM_END   = 4'd8;
   localparam logic [3:0] EV_TRUE      = 4'd9;
   localparam logic [3:0] EV_FALSE     = 4'd10;
   localparam logic [3:0] EV_NULL      = 4'd11;
   localparam logic [3:0] EV_COMMA     = 4'd12;
   localparam logic [3:0] EV_COLON     = 4'd13;

   localparam logic [1:0] ST_BUSY     = 2'd0;
   localparam logic [1:0] ST_ACCEPT   = 2'd1;
   localparam logic [1:0] ST_SYNTAX   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [0:0] REG_MAX_DEPTH = 1'b0;

   typedef enum logic [5:0] {
      S_GO, S_OK, S_OB, S_KE, S_CO, S_VA, S_A0, S_AR, S_ST, S_ES, S_U1, S_U2, S_U3, S_U4,
      S_L1, S_L2, S_MI, S_ZE, S_IT, S_FP, S_FR, S_E1, S_E2, S_E3, S_T1, S_T2, S_T3,
      S_F1, S_F2, S_F3, S_F4, S_N1, S_N2, S_N3
   } pstate_type;

   typedef enum logic [3:0] {
      A_GOTO, A_ERR, A_OO, A_OA, A_SB, A_EO, A_CO, A_EA, A_CA, A_SE, A_NE, A_EC, A_EU,
      A_CM, A_CL
   } act_type;

   typedef enum logic [4:0] {
      C_SP, C_WH, C_LC, C_RC, C_LB, C_RB, C_COL, C_COM, C_Q, C_BS, C_SL, C_PL, C_MN, C_PT,
      C_Z, C_D, C_A, C_B, C_E, C_F, C_L, C_N, C_R, C_S, C_T, C_U, C_HX, C_UE, C_X, C_BAD
   } cclass_type;

   typedef enum logic [1:0] {M_DONE, M_ARRAY, M_KEY, M_OBJECT} mode_type;

   typedef struct packed {
      act_type    act;
      pstate_type st;
   } trans_type;

   typedef struct packed {
      logic     push;
      logic     pop;
      logic     set;
      mode_type mode;
   } stack_cmd_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [20:0] char_value;
      logic        is_key;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]    ev;
      logic [20:0]   val;
      logic          key;
      logic [1:0]    err;
      pstate_type    nstate;
      logic [15:0]   esc;
      logic [15:0]   pend;
      stack_cmd_type cmd;
   } step_type;

   function automatic cclass_type classify(input logic [20:0] cp);
      cclass_type c;
      if (cp >= 21'd126) begin
         c = C_X;
      end else if (cp == 21'd32) begin
         c = C_SP;
      end else if (cp == 21'd9 || cp == 21'd10 || cp == 21'd13) begin
         c = C_WH;
      end else if (cp < 21'd32) begin
         c = C_BAD;
      end else if (cp >= 21'h31 && cp <= 21'h39) begin
         c = C_D;
      end else begin
         unique case (cp[6:0])
            7'h7B: c = C_LC;
            7'h7D: c = C_RC;
            7'h5B: c = C_LB;
            7'h5D: c = C_RB;
            7'h3A: c = C_COL;
            7'h2C: c = C_COM;
            7'h22: c = C_Q;
            7'h5C: c = C_BS;
            7'h2F: c = C_SL;
            7'h2B: c = C_PL;
            7'h2D: c = C_MN;
            7'h2E: c = C_PT;
            7'h30: c = C_Z;
            7'h61: c = C_A;
            7'h62: c = C_B;
            7'h65: c = C_E;
            7'h66: c = C_F;
            7'h6C: c = C_L;
            7'h6E: c = C_N;
            7'h72: c = C_R;
            7'h73: c = C_S;
            7'h74: c = C_T;
            7'h75: c = C_U;
            7'h45: c = C_UE;
            7'h63, 7'h64, 7'h41, 7'h42, 7'h43, 7'h44, 7'h46: c = C_HX;
            default: c = C_X;
         endcase
      end
      return c;
   endfunction

   function automatic logic [3:0] hex_digit(input logic [20:0] cp);
      return (cp[6:0] <= 7'h39) ? cp[3:0] : cp[3:0] - 4'd7;
   endfunction

   function automatic trans_type go(input pstate_type s);
      trans_type t;
      t.act = A_GOTO;
      t.st  = s;
      return t;
   endfunction

   function automatic trans_type act(input act_type a);
      trans_type t;
      t.act = a;
      t.st  = S_GO;
      return t;
   endfunction

   // Grammar table: a plain next state or an action with side effects.
   function automatic trans_type trans(input pstate_type s, input cclass_type c);
      trans_type t;
      logic      ws, hex, dig, term;
      ws   = (c == C_SP) || (c == C_WH);
      dig  = (c == C_Z) || (c == C_D);
      hex  = dig || c == C_A || c == C_B || c == C_E || c == C_F || c == C_HX || c == C_UE;
      term = ws || c == C_RC || c == C_RB || c == C_COM;
      t    = act(A_ERR);
      unique case (s)
         S_GO: begin
            if (ws) t = go(S_GO);
            else if (c == C_LC) t = act(A_OO);
            else if (c == C_LB) t = act(A_OA);
         end
         S_OK: begin
            if (ws) t = go(S_OK);
            else if (c == C_RC) t = act(A_CO);
            else if (c == C_RB) t = act(A_CA);
            else if (c == C_COM) t = act(A_CM);
         end
         S_OB: begin
            if (ws) t = go(S_OB);
            else if (c == C_RC) t = act(A_EO);
            else if (c == C_Q) t = act(A_SB);
         end
         S_KE: begin
            if (ws) t = go(S_KE);
            else if (c == C_Q) t = act(A_SB);
         end
         S_CO: begin
            if (ws) t = go(S_CO);
            else if (c == C_COL) t = act(A_CL);
         end
         S_VA, S_A0, S_AR: begin
            if (ws) t = go(s);
            else if (c == C_LC) t = act(A_OO);
            else if (c == C_LB) t = act(A_OA);
            else if (c == C_Q) t = act(A_SB);
            else if (c == C_MN) t = go(S_MI);
            else if (c == C_Z) t = go(S_ZE);
            else if (c == C_D) t = go(S_IT);
            else if (c == C_F) t = go(S_F1);
            else if (c == C_N) t = go(S_N1);
            else if (c == C_T) t = go(S_T1);
            else if (c == C_RB && s == S_A0) t = act(A_EA);
            else if (c == C_RB && s == S_AR) t = act(A_CA);
         end
         S_ST: begin
            if (c == C_WH) t = act(A_ERR);
            else if (c == C_Q) t = act(A_SE);
            else if (c == C_BS) t = go(S_ES);
            else t = go(S_ST);
         end
         S_ES: begin
            if (c == C_Q || c == C_BS || c == C_SL || c == C_B || c == C_F || c == C_N ||
                c == C_R || c == C_T) t = act(A_EC);
            else if (c == C_U) t = go(S_U1);
         end
         S_U1: if (hex) t = go(S_U2);
         S_U2: if (hex) t = go(S_U3);
         S_U3: if (hex) t = go(S_U4);
         S_U4: if (hex) t = act(A_EU);
         S_L1: if (c == C_BS) t = go(S_L2);
         S_L2: if (c == C_U) t = go(S_U1);
         S_MI: begin
            if (c == C_Z) t = go(S_ZE);
            else if (c == C_D) t = go(S_IT);
         end
         S_ZE: begin
            if (term) t = act(A_NE);
            else if (c == C_PT) t = go(S_FP);
         end
         S_IT: begin
            if (term) t = act(A_NE);
            else if (c == C_PT) t = go(S_FP);
            else if (dig) t = go(S_IT);
            else if (c == C_E || c == C_UE) t = go(S_E1);
         end
         S_FP: if (dig) t = go(S_FR);
         S_FR: begin
            if (term) t = act(A_NE);
            else if (dig) t = go(S_FR);
            else if (c == C_E || c == C_UE) t = go(S_E1);
         end
         S_E1: begin
            if (c == C_PL || c == C_MN) t = go(S_E2);
            else if (dig) t = go(S_E3);
         end
         S_E2: if (dig) t = go(S_E3);
         S_E3: begin
            if (term) t = act(A_NE);
            else if (dig) t = go(S_E3);
         end
         S_T1: if (c == C_R) t = go(S_T2);
         S_T2: if (c == C_U) t = go(S_T3);
         S_T3: if (c == C_E) t = go(S_OK);
         S_F1: if (c == C_A) t = go(S_F2);
         S_F2: if (c == C_L) t = go(S_F3);
         S_F3: if (c == C_S) t = go(S_F4);
         S_F4: if (c == C_E) t = go(S_OK);
         S_N1: if (c == C_U) t = go(S_N2);
         S_N2: if (c == C_L) t = go(S_N3);
         S_N3: if (c == C_L) t = go(S_OK);
         default: t = act(A_ERR);
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

### sv/jst_step.sv
// One pass of the grammar machine over one character.
`timescale 1ns / 1ps
`default_nettype none
module jst_step (
   input  var jst_pkg::pstate_type          state,
   input  var jst_pkg::cclass_type          cls,
   input  var logic [20:0]                  cp,
   input  var jst_pkg::mode_type            mode,
   input  var logic [jst_pkg::STACK_AW-1:0] depth,
   input  var logic [15:0]                  esc,
   input  var logic [15:0]                  pend,
   input  var logic [jst_pkg::LIMIT_W-1:0]  limit,
   output jst_pkg::step_type                res
);

   jst_pkg::trans_type t;
   logic [3:0]         hex;
   logic [15:0]        uval;
   jst_pkg::mode_type  want;

   assign t    = jst_pkg::trans(state, cls);
   assign hex  = jst_pkg::hex_digit(cp);
   assign uval = {esc[11:0], hex};

   always_comb begin
      res        = '0;
      res.nstate = state;
      res.esc    = esc;
      res.pend   = pend;
      want       = jst_pkg::M_ARRAY;
      if (t.act == jst_pkg::A_GOTO) begin
         res.nstate = t.st;
         unique case (t.st)
            jst_pkg::S_T1: res.ev = jst_pkg::EV_TRUE;
            jst_pkg::S_F1: res.ev = jst_pkg::EV_FALSE;
            jst_pkg::S_N1: res.ev = jst_pkg::EV_NULL;
            jst_pkg::S_ST: begin
               res.ev  = jst_pkg::EV_STR_CHAR;
               res.val = cp;
            end
            jst_pkg::S_MI, jst_pkg::S_ZE, jst_pkg::S_IT, jst_pkg::S_FP, jst_pkg::S_FR,
            jst_pkg::S_E1, jst_pkg::S_E2, jst_pkg::S_E3: begin
               res.ev  = jst_pkg::EV_NUM_CHAR;
               res.val = cp;
            end
            jst_pkg::S_U2: res.esc = esc | {12'd0, hex};
            jst_pkg::S_U3, jst_pkg::S_U4: res.esc = uval;
            default: res.ev = jst_pkg::EV_NONE;
         endcase
      end else begin
         unique case (t.act)
            jst_pkg::A_SB: res.nstate = jst_pkg::S_ST;
            jst_pkg::A_EC: begin
               unique case (cp[6:0])
                  7'h62:   res.val = 21'd8;
                  7'h66:   res.val = 21'd12;
                  7'h6E:   res.val = 21'd10;
                  7'h72:   res.val = 21'd13;
                  7'h74:   res.val = 21'd9;
                  default: res.val = cp;
               endcase
               res.ev     = jst_pkg::EV_STR_CHAR;
               res.nstate = jst_pkg::S_ST;
            end
            jst_pkg::A_EU: begin
               res.esc = '0;
               if (uval >= 16'hD800 && uval < 16'hDC00) begin
                  res.pend   = uval;
                  res.nstate = jst_pkg::S_L1;
               end else if (pend != '0) begin
                  if (uval < 16'hDC00 || uval >= 16'hE000) begin
                     res.err = jst_pkg::ST_SYNTAX;
                  end else begin
                     // A surrogate pair folds into one supplementary character.
                     res.val    = 21'h10000 + {1'b0, pend[9:0], 10'd0} + {11'd0, uval[9:0]};
                     res.pend   = '0;
                     res.ev     = jst_pkg::EV_STR_CHAR;
                     res.nstate = jst_pkg::S_ST;
                  end
               end else begin
                  res.val    = {5'd0, uval};
                  res.ev     = jst_pkg::EV_STR_CHAR;
                  res.nstate = jst_pkg::S_ST;
               end
            end
            jst_pkg::A_OO, jst_pkg::A_OA: begin
               if ({{(jst_pkg::LIMIT_W - jst_pkg::STACK_AW){1'b0}}, depth} + 1'b1 >= limit)
               begin
                  res.err = jst_pkg::ST_OVERFLOW;
               end else begin
                  res.cmd.push = 1'b1;
                  if (t.act == jst_pkg::A_OO) begin
                     res.cmd.mode = jst_pkg::M_KEY;
                     res.nstate   = jst_pkg::S_OB;
                     res.ev       = jst_pkg::EV_OPEN_OBJ;
                  end else begin
                     res.cmd.mode = jst_pkg::M_ARRAY;
                     res.nstate   = jst_pkg::S_A0;
                     res.ev       = jst_pkg::EV_OPEN_ARR;
                  end
               end
            end
            jst_pkg::A_EO, jst_pkg::A_CO, jst_pkg::A_EA, jst_pkg::A_CA: begin
               if (t.act == jst_pkg::A_EO) want = jst_pkg::M_KEY;
               else if (t.act == jst_pkg::A_CO) want = jst_pkg::M_OBJECT;
               else want = jst_pkg::M_ARRAY;
               if (mode != want || depth == '0) begin
                  res.err = jst_pkg::ST_SYNTAX;
               end else begin
                  res.cmd.pop = 1'b1;
                  res.nstate  = jst_pkg::S_OK;
                  res.ev      = (want == jst_pkg::M_ARRAY) ? jst_pkg::EV_CLOSE_ARR
                                                           : jst_pkg::EV_CLOSE_OBJ;
               end
            end
            jst_pkg::A_SE: begin
               if (mode == jst_pkg::M_KEY) begin
                  res.nstate = jst_pkg::S_CO;
                  res.key    = 1'b1;
                  res.ev     = jst_pkg::EV_STR_END;
               end else if (mode == jst_pkg::M_ARRAY || mode == jst_pkg::M_OBJECT) begin
                  res.nstate = jst_pkg::S_OK;
                  res.ev     = jst_pkg::EV_STR_END;
               end else begin
                  res.err = jst_pkg::ST_SYNTAX;
               end
            end
            jst_pkg::A_NE: begin
               res.nstate = jst_pkg::S_OK;
               res.ev     = jst_pkg::EV_NUM_END;
            end
            jst_pkg::A_CM: begin
               if (mode == jst_pkg::M_OBJECT) begin
                  res.cmd.set  = 1'b1;
                  res.cmd.mode = jst_pkg::M_KEY;
                  res.nstate   = jst_pkg::S_KE;
                  res.ev       = jst_pkg::EV_COMMA;
               end else if (mode == jst_pkg::M_ARRAY) begin
                  res.nstate = jst_pkg::S_VA;
                  res.ev     = jst_pkg::EV_COMMA;
               end else begin
                  res.err = jst_pkg::ST_SYNTAX;
               end
            end
            jst_pkg::A_CL: begin
               if (mode != jst_pkg::M_KEY) begin
                  res.err = jst_pkg::ST_SYNTAX;
               end else begin
                  res.cmd.set  = 1'b1;
                  res.cmd.mode = jst_pkg::M_OBJECT;
                  res.nstate   = jst_pkg::S_VA;
                  res.ev       = jst_pkg::EV_COLON;
               end
            end
            default: res.err = jst_pkg::ST_SYNTAX;
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/jst_mode_stack.sv
// Nesting mode stack: top entry in a register, lower entries in a memory.
`timescale 1ns / 1ps
`default_nettype none
module jst_mode_stack (
   input  var logic                          clock,
   input  var logic                          reset,
   input  var logic                          clear,
   input  var jst_pkg::stack_cmd_type        cmd,
   output jst_pkg::mode_type                 mode_top,
   output logic [jst_pkg::STACK_AW-1:0]      depth
);

   jst_pkg::mode_type                 mem [jst_pkg::STACK_ENTRIES];
   jst_pkg::mode_type                 top_ff, top_in;
   jst_pkg::mode_type                 below_ff;
   logic [jst_pkg::STACK_AW-1:0]      depth_ff, depth_in;
   logic [jst_pkg::STACK_AW-1:0]      rd_addr;

   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      if (clear) begin
         depth_in = '0;
         top_in   = jst_pkg::M_DONE;
      end else if (cmd.push) begin
         depth_in = depth_ff + 1'b1;
         top_in   = cmd.mode;
      end else if (cmd.pop) begin
         depth_in = depth_ff - 1'b1;
         top_in   = below_ff;
      end else if (cmd.set) begin
         top_in = cmd.mode;
      end
   end

   // The entry under the new top is fetched ahead so a pop can use it next cycle.
   assign rd_addr = depth_in - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.push && !clear) begin
         mem[depth_ff] <= top_ff;
         below_ff      <= top_ff;
      end else begin
         below_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         top_ff   <= jst_pkg::M_DONE;
      end else begin
         depth_ff <= depth_in;
         top_ff   <= top_in;
      end
   end

   assign mode_top = top_ff;
   assign depth    = depth_ff;

endmodule
`default_nettype wire

### sv/jst_rsp_queue.sv
// Result queue that takes up to two items per cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none
module jst_rsp_queue (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             push0,
   input  var logic             push1,
   input  var jst_pkg::rsp_type data0,
   input  var jst_pkg::rsp_type data1,
   input  var logic             pop,
   output jst_pkg::rsp_type     head,
   output logic                 head_valid,
   output logic                 room
);

   jst_pkg::rsp_type               entry_ff [jst_pkg::RSP_DEPTH];
   logic [jst_pkg::RSP_AW-1:0]     wr_ff, rd_ff;
   logic [jst_pkg::RSP_CW-1:0]     count_ff, count_in;
   logic [jst_pkg::RSP_AW-1:0]     wr_next;

   assign wr_next  = wr_ff + 1'b1;
   assign count_in = count_ff + jst_pkg::RSP_CW'(push0) + jst_pkg::RSP_CW'(push1)
                     - jst_pkg::RSP_CW'(pop);

   always_ff @(posedge clock) begin
      if (push0) entry_ff[wr_ff] <= data0;
      if (push1) entry_ff[wr_next] <= data1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + jst_pkg::RSP_AW'(push0) + jst_pkg::RSP_AW'(push1);
         rd_ff    <= rd_ff + jst_pkg::RSP_AW'(pop);
         count_ff <= count_in;
      end
   end

   assign head       = entry_ff[rd_ff];
   assign head_valid = (count_ff != '0);
   assign room       = (count_ff <= jst_pkg::RSP_CW'(jst_pkg::RSP_DEPTH - 2));

endmodule
`default_nettype wire

### sv/json_syntax_tokenizer_unit.sv
// Top level of the JSON syntax tokenizer: input register, grammar step and result queue.
`timescale 1ns / 1ps
`default_nettype none
// One decoded character is taken per item and the tokenizer accepts a new item every
// cycle unless input is held off as set out below. Each item sits in the input register,
// where the grammar table, the top of the nesting stack and the escape registers settle
// its results in one pass, with a second pass for a character that ends a number; once the
// result queue has room they go into a four-entry result queue. A character that ends a
// number can give two results; input is held off only while the input register holds an
// item and the result queue has fewer than two free entries. The nesting stack keeps its
// top entry in a register and the rest in a memory read one entry ahead, so no clearing
// pass is needed after reset.
module json_syntax_tokenizer_unit (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_valid,
   output logic            req_ready,
   input  var logic [20:0] req_code_point,
   input  var logic        req_end_of_text,
   output logic            rsp_valid,
   input  var logic        rsp_ready,
   output logic [3:0]      rsp_event_res,
   output logic [20:0]     rsp_char_value,
   output logic            rsp_is_key,
   output logic [1:0]      rsp_status,
   output logic            rsp_last,
   input  var logic        csr_psel,
   input  var logic        csr_penable,
   input  var logic        csr_pwrite,
   input  var logic [2:0]  csr_paddr,
   input  var logic [31:0] csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   logic                         in_valid_ff;
   logic [20:0]                  cp_ff;
   logic                         eot_ff;
   jst_pkg::pstate_type          state_ff, state_in;
   logic [15:0]                  esc_ff, esc_in;
   logic [15:0]                  pend_ff, pend_in;
   logic [1:0]                   err_ff, err_in;
   logic [6:0]                   max_depth_ff;
   logic [jst_pkg::LIMIT_W-1:0]  limit;
   jst_pkg::cclass_type          cls;
   jst_pkg::mode_type            stk_mode;
   logic [jst_pkg::STACK_AW-1:0] stk_depth;
   jst_pkg::step_type            p1, p2;
   jst_pkg::stack_cmd_type       cmd;
   jst_pkg::rsp_type             r0, r1, head;
   logic                         two;
   logic                         room;
   logic                         step_go;
   logic                         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == jst_pkg::REG_MAX_DEPTH) ? {25'd0, max_depth_ff}
                                                               : 32'd0;

   assign step_go   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   assign cls   = jst_pkg::classify(cp_ff);
   assign limit = (jst_pkg::LIMIT_W'(max_depth_ff) >
                   jst_pkg::LIMIT_W'(jst_pkg::STACK_ENTRIES))
                  ? jst_pkg::LIMIT_W'(jst_pkg::STACK_ENTRIES)
                  : jst_pkg::LIMIT_W'(max_depth_ff);

   jst_step u_pass1 (
      .state (state_ff), .cls (cls), .cp (cp_ff), .mode (stk_mode), .depth (stk_depth),
      .esc (esc_ff), .pend (pend_ff), .limit (limit), .res (p1)
   );

   // A number end runs its terminator again from the value-done state.
   jst_step u_pass2 (
      .state (jst_pkg::S_OK), .cls (cls), .cp (cp_ff), .mode (stk_mode),
      .depth (stk_depth), .esc (esc_ff), .pend (pend_ff), .limit (limit), .res (p2)
   );

   always_comb begin
      r0        = '0;
      r1        = '0;
      two       = 1'b0;
      cmd       = '0;
      state_in  = state_ff;
      esc_in    = esc_ff;
      pend_in   = pend_ff;
      err_in    = err_ff;
      r0.last   = 1'b1;
      if (eot_ff) begin
         if (err_ff != jst_pkg::ST_BUSY) r0.status = err_ff;
         else if (state_ff == jst_pkg::S_OK && stk_mode == jst_pkg::M_DONE)
            r0.status = jst_pkg::ST_ACCEPT;
         else r0.status = jst_pkg::ST_SYNTAX;
         state_in = jst_pkg::S_GO;
         esc_in   = '0;
         pend_in  = '0;
         err_in   = jst_pkg::ST_BUSY;
      end else if (err_ff != jst_pkg::ST_BUSY) begin
         r0.status = err_ff;
      end else if (cls == jst_pkg::C_BAD) begin
         r0.status = jst_pkg::ST_SYNTAX;
         err_in    = jst_pkg::ST_SYNTAX;
      end else begin
         r0.event_res  = p1.ev;
         r0.char_value = p1.val;
         r0.is_key     = p1.key;
         r0.status     = p1.err;
         if (p1.ev == jst_pkg::EV_NUM_END) begin
            two          = (p2.ev != jst_pkg::EV_NONE) || (p2.err != jst_pkg::ST_BUSY);
            r0.last      = !two;
            r1.event_res = p2.ev;
            r1.char_value = p2.val;
            r1.is_key    = p2.key;
            r1.status    = p2.err;
            r1.last      = 1'b1;
            state_in     = p2.nstate;
            esc_in       = p2.esc;
            pend_in      = p2.pend;
            err_in       = p2.err;
            cmd          = p2.cmd;
         end else begin
            state_in = p1.nstate;
            esc_in   = p1.esc;
            pend_in  = p1.pend;
            err_in   = p1.err;
            cmd      = p1.cmd;
         end
      end
      if (!step_go) cmd = '0;
   end

   jst_mode_stack u_stack (
      .clock (clock), .reset (reset), .clear (step_go && eot_ff), .cmd (cmd),
      .mode_top (stk_mode), .depth (stk_depth)
   );

   jst_rsp_queue u_queue (
      .clock (clock), .reset (reset), .push0 (step_go), .push1 (step_go && two),
      .data0 (r0), .data1 (r1), .pop (rsp_valid && rsp_ready), .head (head),
      .head_valid (rsp_valid), .room (room)
   );

   assign rsp_event_res  = head.event_res;
   assign rsp_char_value = head.char_value;
   assign rsp_is_key     = head.is_key;
   assign rsp_status     = head.status;
   assign rsp_last       = head.last;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cp_ff  <= req_code_point;
         eot_ff <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= jst_pkg::S_GO;
         esc_ff       <= '0;
         pend_ff      <= '0;
         err_ff       <= jst_pkg::ST_BUSY;
         max_depth_ff <= jst_pkg::MAX_DEPTH_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (step_go) begin
            state_ff <= state_in;
            esc_ff   <= esc_in;
            pend_ff  <= pend_in;
            err_ff   <= err_in;
         end
         if (csr_wr && csr_paddr[2] == jst_pkg::REG_MAX_DEPTH) begin
            max_depth_ff <= csr_pwdata[6:0];
         end
      end
   end

   // Only the document level holds the done mode.
   a_done_at_root: assert property (@(posedge clock) disable iff (reset)
      (stk_mode == jst_pkg::M_DONE) == (stk_depth == '0))
      else $error("done mode seen away from document level");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (step_go && eot_ff) |=> (stk_depth == '0 && err_ff == jst_pkg::ST_BUSY &&
                               state_ff == jst_pkg::S_GO))
      else $error("end of text did not clear the parser");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != jst_pkg::ST_BUSY && !(step_go && eot_ff)) |=> (err_ff == $past(err_ff)))
      else $error("latched error changed before end of text");

endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for the JSON syntax tokenizer: directed table, random documents, self-checking.
`timescale 1ns / 1ps
module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_GOAL   = 1700;

   typedef struct {
      logic [3:0]  ev;
      logic [20:0] val;
      logic        key;
      logic [1:0]  st;
      logic        last;
   } token_type;

   typedef struct {
      logic                is_act;
      jst_pkg::act_type    a;
      jst_pkg::pstate_type s;
   } move_type;

   typedef struct {
      logic [20:0] cp;
      logic        eot;
      logic        typed;
      logic [3:0]  ev;
      logic [1:0]  st;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [20:0] req_code_point = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_res;
   logic [20:0] rsp_char_value;
   logic        rsp_is_key;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   json_syntax_tokenizer_unit DUT (.*);

   always #2 clock = ~clock;

   // Tokenizer shadow state.
   jst_pkg::pstate_type tk_state;
   jst_pkg::mode_type   tk_mode[jst_pkg::STACK_ENTRIES];
   int                  tk_top;
   logic [15:0]         tk_esc;
   logic [15:0]         tk_pend;
   logic [1:0]          tk_err;
   logic [6:0]          tk_max_depth;

   token_type   expected_tokens[$];
   logic [20:0] doc[$];
   int          errors = 0;
   int          cycles = 0;
   int          items_sent = 0;
   bit          quiet = 0;
   bit          hold_req = 0;
   int          rsp_stall = 0;

   function automatic void clear_parse();
      tk_state = jst_pkg::S_GO;
      foreach (tk_mode[i]) tk_mode[i] = jst_pkg::M_DONE;
      tk_top  = 0;
      tk_esc  = '0;
      tk_pend = '0;
      tk_err  = jst_pkg::ST_BUSY;
   endfunction

   function automatic jst_pkg::cclass_type char_class(logic [20:0] c);
      if (c >= 126) return jst_pkg::C_X;
      if (c == 32) return jst_pkg::C_SP;
      if (c == 9 || c == 10 || c == 13) return jst_pkg::C_WH;
      if (c < 32) return jst_pkg::C_BAD;
      if (c >= "1" && c <= "9") return jst_pkg::C_D;
      case (c)
         "{": return jst_pkg::C_LC;
         "}": return jst_pkg::C_RC;
         "[": return jst_pkg::C_LB;
         "]": return jst_pkg::C_RB;
         ":": return jst_pkg::C_COL;
         ",": return jst_pkg::C_COM;
         "\"": return jst_pkg::C_Q;
         "\\": return jst_pkg::C_BS;
         "/": return jst_pkg::C_SL;
         "+": return jst_pkg::C_PL;
         "-": return jst_pkg::C_MN;
         ".": return jst_pkg::C_PT;
         "0": return jst_pkg::C_Z;
         "a": return jst_pkg::C_A;
         "b": return jst_pkg::C_B;
         "e": return jst_pkg::C_E;
         "f": return jst_pkg::C_F;
         "l": return jst_pkg::C_L;
         "n": return jst_pkg::C_N;
         "r": return jst_pkg::C_R;
         "s": return jst_pkg::C_S;
         "t": return jst_pkg::C_T;
         "u": return jst_pkg::C_U;
         "E": return jst_pkg::C_UE;
         "c", "d", "A", "B", "C", "D", "F": return jst_pkg::C_HX;
         default: return jst_pkg::C_X;
      endcase
   endfunction

   function automatic logic [3:0] hex_value(logic [20:0] c);
      logic [20:0] d;
      if (c <= "9") d = c - "0";
      else if (c <= "F") d = c - 55;
      else d = c - 87;
      return d[3:0];
   endfunction

   function automatic move_type to(jst_pkg::pstate_type s);
      move_type m;
      m = '{1'b0, jst_pkg::A_GOTO, s};
      return m;
   endfunction

   function automatic move_type doing(jst_pkg::act_type a);
      move_type m;
      m = '{1'b1, a, jst_pkg::S_GO};
      return m;
   endfunction

   function automatic move_type lookup(jst_pkg::pstate_type s, jst_pkg::cclass_type c);
      move_type m;
      logic ws, dg, hx, endn;
      ws   = c inside {jst_pkg::C_SP, jst_pkg::C_WH};
      dg   = c inside {jst_pkg::C_Z, jst_pkg::C_D};
      hx   = dg || (c inside {jst_pkg::C_A, jst_pkg::C_B, jst_pkg::C_E, jst_pkg::C_F,
                              jst_pkg::C_HX, jst_pkg::C_UE});
      endn = ws || (c inside {jst_pkg::C_RC, jst_pkg::C_RB, jst_pkg::C_COM});
      m    = doing(jst_pkg::A_ERR);
      case (s)
         jst_pkg::S_GO: begin
            if (ws) m = to(jst_pkg::S_GO);
            else if (c == jst_pkg::C_LC) m = doing(jst_pkg::A_OO);
            else if (c == jst_pkg::C_LB) m = doing(jst_pkg::A_OA);
         end
         jst_pkg::S_OK: begin
            if (ws) m = to(jst_pkg::S_OK);
            else if (c == jst_pkg::C_RC) m = doing(jst_pkg::A_CO);
            else if (c == jst_pkg::C_RB) m = doing(jst_pkg::A_CA);
            else if (c == jst_pkg::C_COM) m = doing(jst_pkg::A_CM);
         end
         jst_pkg::S_OB: begin
            if (ws) m = to(jst_pkg::S_OB);
            else if (c == jst_pkg::C_RC) m = doing(jst_pkg::A_EO);
            else if (c == jst_pkg::C_Q) m = doing(jst_pkg::A_SB);
         end
         jst_pkg::S_KE: begin
            if (ws) m = to(jst_pkg::S_KE);
            else if (c == jst_pkg::C_Q) m = doing(jst_pkg::A_SB);
         end
         jst_pkg::S_CO: begin
            if (ws) m = to(jst_pkg::S_CO);
            else if (c == jst_pkg::C_COL) m = doing(jst_pkg::A_CL);
         end
         jst_pkg::S_VA, jst_pkg::S_A0, jst_pkg::S_AR: begin
            if (ws) m = to(s);
            else if (c == jst_pkg::C_LC) m = doing(jst_pkg::A_OO);
            else if (c == jst_pkg::C_LB) m = doing(jst_pkg::A_OA);
            else if (c == jst_pkg::C_Q) m = doing(jst_pkg::A_SB);
            else if (c == jst_pkg::C_MN) m = to(jst_pkg::S_MI);
            else if (c == jst_pkg::C_Z) m = to(jst_pkg::S_ZE);
            else if (c == jst_pkg::C_D) m = to(jst_pkg::S_IT);
            else if (c == jst_pkg::C_F) m = to(jst_pkg::S_F1);
            else if (c == jst_pkg::C_N) m = to(jst_pkg::S_N1);
            else if (c == jst_pkg::C_T) m = to(jst_pkg::S_T1);
            else if (c == jst_pkg::C_RB && s == jst_pkg::S_A0) m = doing(jst_pkg::A_EA);
            else if (c == jst_pkg::C_RB && s == jst_pkg::S_AR) m = doing(jst_pkg::A_CA);
         end
         jst_pkg::S_ST: begin
            if (c == jst_pkg::C_WH) m = doing(jst_pkg::A_ERR);
            else if (c == jst_pkg::C_Q) m = doing(jst_pkg::A_SE);
            else if (c == jst_pkg::C_BS) m = to(jst_pkg::S_ES);
            else m = to(jst_pkg::S_ST);
         end
         jst_pkg::S_ES: begin
            if (c inside {jst_pkg::C_Q, jst_pkg::C_BS, jst_pkg::C_SL, jst_pkg::C_B,
                          jst_pkg::C_F, jst_pkg::C_N, jst_pkg::C_R, jst_pkg::C_T})
               m = doing(jst_pkg::A_EC);
            else if (c == jst_pkg::C_U) m = to(jst_pkg::S_U1);
         end
         jst_pkg::S_U1: if (hx) m = to(jst_pkg::S_U2);
         jst_pkg::S_U2: if (hx) m = to(jst_pkg::S_U3);
         jst_pkg::S_U3: if (hx) m = to(jst_pkg::S_U4);
         jst_pkg::S_U4: if (hx) m = doing(jst_pkg::A_EU);
         jst_pkg::S_L1: if (c == jst_pkg::C_BS) m = to(jst_pkg::S_L2);
         jst_pkg::S_L2: if (c == jst_pkg::C_U) m = to(jst_pkg::S_U1);
         jst_pkg::S_MI: begin
            if (c == jst_pkg::C_Z) m = to(jst_pkg::S_ZE);
            else if (c == jst_pkg::C_D) m = to(jst_pkg::S_IT);
         end
         jst_pkg::S_ZE: begin
            if (endn) m = doing(jst_pkg::A_NE);
            else if (c == jst_pkg::C_PT) m = to(jst_pkg::S_FP);
         end
         jst_pkg::S_IT: begin
            if (endn) m = doing(jst_pkg::A_NE);
            else if (c == jst_pkg::C_PT) m = to(jst_pkg::S_FP);
            else if (dg) m = to(jst_pkg::S_IT);
            else if (c inside {jst_pkg::C_E, jst_pkg::C_UE}) m = to(jst_pkg::S_E1);
         end
         jst_pkg::S_FP: if (dg) m = to(jst_pkg::S_FR);
         jst_pkg::S_FR: begin
            if (endn) m = doing(jst_pkg::A_NE);
            else if (dg) m = to(jst_pkg::S_FR);
            else if (c inside {jst_pkg::C_E, jst_pkg::C_UE}) m = to(jst_pkg::S_E1);
         end
         jst_pkg::S_E1: begin
            if (c inside {jst_pkg::C_PL, jst_pkg::C_MN}) m = to(jst_pkg::S_E2);
            else if (dg) m = to(jst_pkg::S_E3);
         end
         jst_pkg::S_E2: if (dg) m = to(jst_pkg::S_E3);
         jst_pkg::S_E3: begin
            if (endn) m = doing(jst_pkg::A_NE);
            else if (dg) m = to(jst_pkg::S_E3);
         end
         jst_pkg::S_T1: if (c == jst_pkg::C_R) m = to(jst_pkg::S_T2);
         jst_pkg::S_T2: if (c == jst_pkg::C_U) m = to(jst_pkg::S_T3);
         jst_pkg::S_T3: if (c == jst_pkg::C_E) m = to(jst_pkg::S_OK);
         jst_pkg::S_F1: if (c == jst_pkg::C_A) m = to(jst_pkg::S_F2);
         jst_pkg::S_F2: if (c == jst_pkg::C_L) m = to(jst_pkg::S_F3);
         jst_pkg::S_F3: if (c == jst_pkg::C_S) m = to(jst_pkg::S_F4);
         jst_pkg::S_F4: if (c == jst_pkg::C_E) m = to(jst_pkg::S_OK);
         jst_pkg::S_N1: if (c == jst_pkg::C_U) m = to(jst_pkg::S_N2);
         jst_pkg::S_N2: if (c == jst_pkg::C_L) m = to(jst_pkg::S_N3);
         jst_pkg::S_N3: if (c == jst_pkg::C_L) m = to(jst_pkg::S_OK);
         default: m = doing(jst_pkg::A_ERR);
      endcase
      return m;
   endfunction

   // One pass of the grammar machine; returns the token event.
   function automatic logic [3:0] token_pass(jst_pkg::cclass_type c, logic [20:0] cp,
                                             output logic [20:0] val, output logic key);
      move_type          m;
      jst_pkg::mode_type md, want;
      int                lim;
      logic [15:0]       v;
      logic [20:0]       full;
      val = '0;
      key = 1'b0;
      m   = lookup(tk_state, c);
      md  = tk_mode[tk_top];
      if (!m.is_act) begin
         tk_state = m.s;
         case (m.s)
            jst_pkg::S_T1: return jst_pkg::EV_TRUE;
            jst_pkg::S_F1: return jst_pkg::EV_FALSE;
            jst_pkg::S_N1: return jst_pkg::EV_NULL;
            jst_pkg::S_ST: begin
               val = cp;
               return jst_pkg::EV_STR_CHAR;
            end
            jst_pkg::S_MI, jst_pkg::S_ZE, jst_pkg::S_IT, jst_pkg::S_FP, jst_pkg::S_FR,
            jst_pkg::S_E1, jst_pkg::S_E2, jst_pkg::S_E3: begin
               val = cp;
               return jst_pkg::EV_NUM_CHAR;
            end
            jst_pkg::S_U2: tk_esc = tk_esc | 16'(hex_value(cp));
            jst_pkg::S_U3, jst_pkg::S_U4: tk_esc = {tk_esc[11:0], hex_value(cp)};
            default: ;
         endcase
         return jst_pkg::EV_NONE;
      end
      case (m.a)
         jst_pkg::A_SB: begin
            tk_state = jst_pkg::S_ST;
            return jst_pkg::EV_NONE;
         end
         jst_pkg::A_EC: begin
            case (cp)
               "b": val = 8;
               "f": val = 12;
               "n": val = 10;
               "r": val = 13;
               "t": val = 9;
               default: val = cp;
            endcase
            tk_state = jst_pkg::S_ST;
            return jst_pkg::EV_STR_CHAR;
         end
         jst_pkg::A_EU: begin
            v = {tk_esc[11:0], hex_value(cp)};
            tk_esc = '0;
            if (v >= 16'hD800 && v < 16'hDC00) begin
               tk_pend  = v;
               tk_state = jst_pkg::S_L1;
               return jst_pkg::EV_NONE;
            end
            full = 21'(v);
            if (tk_pend != 0) begin
               if (v < 16'hDC00 || v >= 16'hE000) begin
                  tk_err = jst_pkg::ST_SYNTAX;
                  return jst_pkg::EV_NONE;
               end
               full = 21'h10000 + (21'(tk_pend[9:0]) << 10) + 21'(v[9:0]);
               tk_pend = '0;
            end
            val = full;
            tk_state = jst_pkg::S_ST;
            return jst_pkg::EV_STR_CHAR;
         end
         jst_pkg::A_OO, jst_pkg::A_OA: begin
            lim = (tk_max_depth > jst_pkg::STACK_ENTRIES) ? jst_pkg::STACK_ENTRIES
                                                          : tk_max_depth;
            if (tk_top + 1 >= lim) begin
               tk_err = jst_pkg::ST_OVERFLOW;
               return jst_pkg::EV_NONE;
            end
            tk_top++;
            tk_mode[tk_top] = (m.a == jst_pkg::A_OO) ? jst_pkg::M_KEY : jst_pkg::M_ARRAY;
            tk_state = (m.a == jst_pkg::A_OO) ? jst_pkg::S_OB : jst_pkg::S_A0;
            return (m.a == jst_pkg::A_OO) ? jst_pkg::EV_OPEN_OBJ : jst_pkg::EV_OPEN_ARR;
         end
         jst_pkg::A_EO, jst_pkg::A_CO, jst_pkg::A_EA, jst_pkg::A_CA: begin
            want = (m.a == jst_pkg::A_EO) ? jst_pkg::M_KEY :
                   (m.a == jst_pkg::A_CO) ? jst_pkg::M_OBJECT : jst_pkg::M_ARRAY;
            if (md != want || tk_top == 0) begin
               tk_err = jst_pkg::ST_SYNTAX;
               return jst_pkg::EV_NONE;
            end
            tk_top--;
            tk_state = jst_pkg::S_OK;
            return (want == jst_pkg::M_ARRAY) ? jst_pkg::EV_CLOSE_ARR : jst_pkg::EV_CLOSE_OBJ;
         end
         jst_pkg::A_SE: begin
            if (md == jst_pkg::M_KEY) begin
               tk_state = jst_pkg::S_CO;
               key = 1'b1;
            end else if (md == jst_pkg::M_ARRAY || md == jst_pkg::M_OBJECT) begin
               tk_state = jst_pkg::S_OK;
            end else begin
               tk_err = jst_pkg::ST_SYNTAX;
               return jst_pkg::EV_NONE;
            end
            return jst_pkg::EV_STR_END;
         end
         jst_pkg::A_NE: begin
            tk_state = jst_pkg::S_OK;
            return jst_pkg::EV_NUM_END;
         end
         jst_pkg::A_CM: begin
            if (md == jst_pkg::M_OBJECT) begin
               tk_mode[tk_top] = jst_pkg::M_KEY;
               tk_state = jst_pkg::S_KE;
            end else if (md == jst_pkg::M_ARRAY) begin
               tk_state = jst_pkg::S_VA;
            end else begin
               tk_err = jst_pkg::ST_SYNTAX;
               return jst_pkg::EV_NONE;
            end
            return jst_pkg::EV_COMMA;
         end
         jst_pkg::A_CL: begin
            if (md != jst_pkg::M_KEY) begin
               tk_err = jst_pkg::ST_SYNTAX;
               return jst_pkg::EV_NONE;
            end
            tk_mode[tk_top] = jst_pkg::M_OBJECT;
            tk_state = jst_pkg::S_VA;
            return jst_pkg::EV_COLON;
         end
         default: begin
            tk_err = jst_pkg::ST_SYNTAX;
            return jst_pkg::EV_NONE;
         end
      endcase
   endfunction

   // Works out the tokens that one accepted character causes.
   function automatic void predict_tokens(logic [20:0] cp, logic eot);
      token_type           buf_q[$];
      jst_pkg::cclass_type c;
      logic [3:0]          ev;
      logic [20:0]         val;
      logic                key;
      logic [1:0]          st;
      if (eot) begin
         if (tk_err != jst_pkg::ST_BUSY) st = tk_err;
         else if (tk_state == jst_pkg::S_OK && tk_mode[tk_top] == jst_pkg::M_DONE)
            st = jst_pkg::ST_ACCEPT;
         else st = jst_pkg::ST_SYNTAX;
         buf_q.push_back('{jst_pkg::EV_NONE, 21'd0, 1'b0, st, 1'b0});
         clear_parse();
      end else if (tk_err != jst_pkg::ST_BUSY) begin
         buf_q.push_back('{jst_pkg::EV_NONE, 21'd0, 1'b0, tk_err, 1'b0});
      end else begin
         c = char_class(cp);
         if (c == jst_pkg::C_BAD) begin
            tk_err = jst_pkg::ST_SYNTAX;
            buf_q.push_back('{jst_pkg::EV_NONE, 21'd0, 1'b0, tk_err, 1'b0});
         end else begin
            ev = token_pass(c, cp, val, key);
            buf_q.push_back('{ev, val, key, tk_err, 1'b0});
            // The character that ends a number is run again from the value-done state.
            if (ev == jst_pkg::EV_NUM_END) begin
               ev = token_pass(c, cp, val, key);
               if (ev != jst_pkg::EV_NONE || tk_err != jst_pkg::ST_BUSY)
                  buf_q.push_back('{ev, val, key, tk_err, 1'b0});
            end
         end
      end
      buf_q[buf_q.size() - 1].last = 1'b1;
      foreach (buf_q[i]) expected_tokens.push_back(buf_q[i]);
   endfunction

   task automatic send_char(logic [20:0] cp, logic eot, logic typed = 0,
                            logic [3:0] tev = jst_pkg::EV_NONE,
                            logic [1:0] tst = jst_pkg::ST_BUSY);
      int        gap;
      token_type t;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_code_point  <= cp;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      predict_tokens(cp, eot);
      if (typed) begin
         t = expected_tokens.pop_back();
         t.ev = tev;
         t.st = tst;
         expected_tokens.push_back(t);
      end
      items_sent++;
   endtask

   task automatic drain_results();
      while (expected_tokens.size() != 0) @(posedge clock);
      // A character with no token may still be in flight.
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tk_max_depth = data[6:0];
   endtask

   // Document generator.
   task automatic add(logic [20:0] c);
      doc.push_back(c);
   endtask

   task automatic add_ws();
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 3))
            0: add(" ");
            1: add(9);
            2: add(10);
            default: add(13);
         endcase
      end
   endtask

   task automatic add_escape_u(logic [15:0] v);
      logic [3:0] d;
      add("\\");
      add("u");
      for (int i = 3; i >= 0; i--) begin
         d = v[4*i +: 4];
         if (d < 10) add("0" + d);
         else add(($urandom_range(0, 1) ? "A" : "a") + d - 10);
      end
   endtask

   task automatic add_string();
      logic [20:0] c;
      logic [15:0] v;
      add("\"");
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               c = $urandom_range(32, 125);
               if (c == "\"" || c == "\\") c = "x";
               add(c);
            end
            3: add($urandom_range(126, 21'h1FFFFF));
            4, 5: begin
               add("\\");
               case ($urandom_range(0, 7))
                  0: add("\"");
                  1: add("\\");
                  2: add("/");
                  3: add("b");
                  4: add("f");
                  5: add("n");
                  6: add("r");
                  default: add("t");
               endcase
            end
            6: begin
               v = $urandom;
               add_escape_u(v);
               if (v >= 16'hD800 && v < 16'hDC00)
                  add_escape_u(16'hDC00 | 16'($urandom_range(0, 1023)));
            end
            7: add_escape_u(16'hDC00 | 16'($urandom_range(0, 1023)));
            8: begin
               // A second high surrogate replaces the pending one.
               add_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
               add_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
               add_escape_u(16'hDC00 | 16'($urandom_range(0, 1023)));
            end
            default: begin
               // High surrogate followed by an escape that is not a low one.
               add_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
               add_escape_u(16'($urandom_range(0, 16'hD7FF)));
            end
         endcase
      end
      add("\"");
   endtask

   task automatic add_digits(int lo, int hi);
      repeat ($urandom_range(lo, hi)) add("0" + $urandom_range(0, 9));
   endtask

   task automatic add_number();
      if ($urandom_range(0, 1)) add("-");
      if ($urandom_range(0, 2) == 0) add("0");
      else begin
         add("1" + $urandom_range(0, 8));
         add_digits(0, 3);
      end
      if ($urandom_range(0, 1)) begin
         add(".");
         add_digits(1, 3);
      end
      if ($urandom_range(0, 2) == 0) begin
         add($urandom_range(0, 1) ? "e" : "E");
         case ($urandom_range(0, 2))
            0: add("+");
            1: add("-");
            default: ;
         endcase
         add_digits(1, 2);
      end
   endtask

   task automatic add_word(string w);
      foreach (w[i]) add(w[i]);
   endtask

   task automatic add_value(int depth);
      case ($urandom_range(0, (depth >= 4) ? 4 : 6))
         0, 1: add_string();
         2, 3: add_number();
         4: begin
            case ($urandom_range(0, 2))
               0: add_word("true");
               1: add_word("false");
               default: add_word("null");
            endcase
         end
         default: add_container(depth + 1, $urandom_range(0, 1));
      endcase
   endtask

   task automatic add_container(int depth, bit obj);
      int n;
      n = $urandom_range(0, 3);
      add(obj ? "{" : "[");
      add_ws();
      for (int i = 0; i < n; i++) begin
         if (i > 0) begin
            add(",");
            add_ws();
         end
         if (obj) begin
            add_string();
            add_ws();
            add(":");
            add_ws();
         end
         add_value(depth);
         add_ws();
      end
      add(obj ? "}" : "]");
   endtask

   task automatic make_document();
      int r, n;
      doc.delete();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 10))
            add($urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 21'h1FFFFF));
      end else if (r < 16) begin
         n = $urandom_range(1, 70);
         repeat (n) add("[");
         repeat (n) add("]");
      end else begin
         add_ws();
         add_container(0, $urandom_range(0, 1));
         add_ws();
      end
      if ($urandom_range(0, 99) < 15 && doc.size() > 0)
         doc[$urandom_range(0, doc.size() - 1)] =
            $urandom_range(0, 3) ? $urandom_range(0, 127) : $urandom_range(0, 21'h1FFFFF);
   endtask

   dir_row_type steps[25] = '{
      '{21'd0, 1'b1, 1'b1, jst_pkg::EV_NONE, jst_pkg::ST_SYNTAX},
      '{21'd0, 1'b0, 1'b1, jst_pkg::EV_NONE, jst_pkg::ST_SYNTAX},
      '{21'd0, 1'b1, 1'b1, jst_pkg::EV_NONE, jst_pkg::ST_SYNTAX},
      '{"[", 1'b0, 1'b1, jst_pkg::EV_OPEN_ARR, jst_pkg::ST_BUSY},
      '{"-", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"5", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"E", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"+", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"9", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{",", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"\"", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{21'h1FFFFF, 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"\"", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"]", 1'b0, 1'b1, jst_pkg::EV_CLOSE_ARR, jst_pkg::ST_BUSY},
      '{21'd0, 1'b1, 1'b1, jst_pkg::EV_NONE, jst_pkg::ST_ACCEPT},
      '{"{", 1'b0, 1'b1, jst_pkg::EV_OPEN_OBJ, jst_pkg::ST_BUSY},
      '{"}", 1'b0, 1'b1, jst_pkg::EV_CLOSE_OBJ, jst_pkg::ST_BUSY},
      '{21'd0, 1'b1, 1'b1, jst_pkg::EV_NONE, jst_pkg::ST_ACCEPT},
      '{"[", 1'b0, 1'b1, jst_pkg::EV_OPEN_ARR, jst_pkg::ST_BUSY},
      '{"t", 1'b0, 1'b1, jst_pkg::EV_TRUE, jst_pkg::ST_BUSY},
      '{"r", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"u", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"e", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{"]", 1'b0, 1'b0, jst_pkg::EV_NONE, jst_pkg::ST_BUSY},
      '{21'd0, 1'b1, 1'b1, jst_pkg::EV_NONE, jst_pkg::ST_ACCEPT}
   };

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: random stalls per item, plus one long hold-off on request.
   always @(posedge clock) begin
      token_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("result item with nothing expected");
               errors++;
            end else begin
               e = expected_tokens.pop_front();
               if (rsp_event_res !== e.ev) begin
                  $error("event_res: expected %0d, got %0d", e.ev, rsp_event_res);
                  errors++;
               end
               if (rsp_char_value !== e.val) begin
                  $error("char_value: expected %0h, got %0h", e.val, rsp_char_value);
                  errors++;
               end
               if (rsp_is_key !== e.key) begin
                  $error("is_key: expected %0d, got %0d", e.key, rsp_is_key);
                  errors++;
               end
               if (rsp_status !== e.st) begin
                  $error("status: expected %0d, got %0d", e.st, rsp_status);
                  errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_last);
                  errors++;
               end
            end
            rsp_stall = quiet ? 0 : $urandom_range(0, 19);
         end
         if (hold_req) begin
            rsp_stall = 400;
            hold_req  = 0;
         end
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int depth_list[8];
      int phase_goal;
      depth_list = '{20, 1, 64, 127, 0, 3, 2, 0};
      depth_list[7] = $urandom_range(1, 64);
      tk_max_depth = jst_pkg::MAX_DEPTH_RESET;
      clear_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i])
         send_char(steps[i].cp, steps[i].eot, steps[i].typed, steps[i].ev, steps[i].st);

      foreach (depth_list[p]) begin
         req_valid <= 1'b0;
         drain_results();
         csr_write(3'(4 * jst_pkg::REG_MAX_DEPTH), depth_list[p]);
         quiet = (p % 3 == 2);
         if (p == 2) hold_req = 1;
         phase_goal = items_sent + ITEM_GOAL / 8;
         while (items_sent < phase_goal) begin
            make_document();
            foreach (doc[i]) send_char(doc[i], 1'b0);
            send_char($urandom_range(0, 21'h1FFFFF), 1'b1);
         end
      end

      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_tokens.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
